// ===== hw/rtl/vggc_pkg.sv =====
// Package: shared constants, codes and types of the voice glide and gate controller.
`timescale 1ns / 1ps
`default_nettype none
package vggc_pkg;

	// ratio format: 8 integer bits, RATIO_FRAC_BITS fraction bits
	localparam int RATIO_FRAC_BITS = 40;
	localparam int RATIO_W         = RATIO_FRAC_BITS + 8;
	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS;
	localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

	localparam int FREQ_W   = 32;
	localparam int SHOWN_W  = 32;
	localparam int GLIDE_W  = 20;

	// shared divider: one quotient bit per cycle
	localparam int DIV_STEPS = RATIO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// item kinds
	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = GLIDE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_GLIDE_SAMPLES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MONO_MODE     = 1'b1;

	typedef struct packed {
		logic                start;
		logic [FREQ_W-1:0]   rem_init;
		logic [RATIO_W-1:0]  dividend;
		logic [FREQ_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic [RATIO_W-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/vggc_if.sv =====
// Interfaces: item channel and result channel of the voice glide and gate controller.
`timescale 1ns / 1ps
`default_nettype none
interface vggc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] previous_frequency;
	logic [31:0] current_frequency;
	logic        key_down;
	logic        allow_tail_off;

	modport source (output valid, kind, previous_frequency, current_frequency, key_down,
		allow_tail_off, input ready);
	modport sink (input valid, kind, previous_frequency, current_frequency, key_down,
		allow_tail_off, output ready);
endinterface

interface vggc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] glide_ratio;
	logic        glide_active;
	logic        gate_on;
	logic        gate_off;
	logic        clear_note;

	modport source (output valid, glide_ratio, glide_active, gate_on, gate_off, clear_note,
		input ready);
	modport sink (input valid, glide_ratio, glide_active, gate_on, gate_off, clear_note,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/vggc_div.sv =====
// Shared restoring divider: one quotient bit per cycle, DIV_STEPS quotient bits per division.
`timescale 1ns / 1ps
`default_nettype none
module vggc_div
	import vggc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FREQ_W-1:0]    rem_q;
	logic [RATIO_W-1:0]   sh_q;     // dividend bits out the top, quotient bits in the bottom
	logic [FREQ_W-1:0]    dvs_q;

	logic [FREQ_W:0]   trial;
	logic              q_bit;
	logic [FREQ_W:0]   diff;

	always_comb begin
		trial = {rem_q, sh_q[RATIO_W-1]};
		q_bit = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// remainder stays below the divisor, so FREQ_W bits hold it
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			sh_q  <= req.dividend;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= q_bit ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			sh_q  <= {sh_q[RATIO_W-2:0], q_bit};
		end
	end

	assign rsp.busy     = cnt_q != '0;
	assign rsp.quotient = sh_q;

endmodule
`default_nettype wire

// ===== hw/rtl/voice_glide_gate_controller.sv =====
// Top level: gate and portamento glide controller of one synthesizer voice.
// Tick, stop, unused kind and non-gliding start go from accept straight to ST_FIN, which loads
// the result beat once the output slot is free. A gliding note start first runs two 48-step
// divisions on the shared divider (ratio, then per-sample step); a saturated ratio skips the first.
// One item at a time: ready only while the sequencer is idle.
// arst_n clears control and voice state: ratio 1.0, no glide, no note, configuration registers zero.
`timescale 1ns / 1ps
`default_nettype none
module voice_glide_gate_controller
	import vggc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	vggc_item_if.sink                  req,
	vggc_result_if.source              rsp
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;   // ratio = prev / cur
	localparam logic [2:0] ST_MAG  = 3'd2;   // distance of ratio from 1.0
	localparam logic [2:0] ST_DIV2 = 3'd3;   // step = distance / glide_samples
	localparam logic [2:0] ST_FIN  = 3'd4;   // commit state, load result beat

	logic [2:0] state_q;

	// configuration
	logic [GLIDE_W-1:0] glide_samples_q;
	logic               mono_mode_q;

	// voice state
	logic               note_trig_q;
	logic               running_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [RATIO_W:0]   step_q;       // signed

	// latched item and note-start work values
	logic [1:0]         kind_q;
	logic               key_q;
	logic               tail_q;
	logic               glide_q;      // this start begins a glide
	logic               dir_q;        // ratio above 1.0: ramp down
	logic [RATIO_W-1:0] ratio_w_q;
	logic [RATIO_W:0]   step_w_q;

	// result register
	logic               out_valid_q;
	logic [SHOWN_W-1:0] out_ratio_q;
	logic               out_active_q;
	logic               out_on_q;
	logic               out_off_q;
	logic               out_clr_q;

	div_req_t dreq;
	div_rsp_t drsp;

	vggc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	logic accept;
	logic glide_cond;
	logic ratio_sat;
	logic [RATIO_W-1:0] mag;
	logic [RATIO_W:0]   quo_x;
	logic slot_free;

	assign req.ready = state_q == ST_IDLE;
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	// legato start with glide enabled, both frequencies nonzero and different
	assign glide_cond = note_trig_q && (glide_samples_q != '0) &&
		(req.previous_frequency != '0) && (req.current_frequency != '0) &&
		(req.previous_frequency != req.current_frequency);
	// quotient reaches 2^RATIO_W exactly when prev >= cur * 256
	assign ratio_sat = {8'b0, req.previous_frequency} >= {req.current_frequency, 8'b0};

	assign mag   = (ratio_w_q > RATIO_ONE) ? ratio_w_q - RATIO_ONE : RATIO_ONE - ratio_w_q;
	assign quo_x = {1'b0, drsp.quotient};

	// divider requests: ratio division from the item, step division from the distance
	always_comb begin
		dreq = '0;
		if (state_q == ST_IDLE) begin
			dreq.start    = accept && (req.kind == KIND_START) && glide_cond && !ratio_sat;
			dreq.rem_init = {8'b0, req.previous_frequency[FREQ_W-1:8]};
			dreq.dividend = {req.previous_frequency[7:0], {RATIO_FRAC_BITS{1'b0}}};
			dreq.divisor  = req.current_frequency;
		end else if (state_q == ST_MAG) begin
			dreq.start    = 1'b1;
			dreq.rem_init = '0;
			dreq.dividend = mag;
			dreq.divisor  = {{(FREQ_W-GLIDE_W){1'b0}}, glide_samples_q};
		end
	end

	// tick arithmetic: add the step, stop once 1.0 is reached or passed
	logic signed [RATIO_W+1:0] tick_sum;
	logic signed [RATIO_W+1:0] one_x;
	logic                      step_neg;
	logic                      step_zero;
	logic                      ramp_end;

	always_comb begin
		one_x     = $signed({2'b00, RATIO_ONE});
		tick_sum  = $signed({2'b00, ratio_q}) + $signed({step_q[RATIO_W], step_q});
		step_neg  = step_q[RATIO_W];
		step_zero = step_q == '0;
		ramp_end  = (!step_neg && (tick_sum >= one_x)) ||
			((step_neg || step_zero) && (tick_sum <= one_x));
	end

	// next voice state and pulses for the latched item
	logic               nx_trig;
	logic               nx_running;
	logic [RATIO_W-1:0] nx_ratio;
	logic [RATIO_W:0]   nx_step;
	logic               nx_on;
	logic               nx_off;
	logic               nx_clr;
	logic [RATIO_W-1:0] nx_shown;

	always_comb begin
		nx_trig    = note_trig_q;
		nx_running = running_q;
		nx_ratio   = ratio_q;
		nx_step    = step_q;
		nx_on      = 1'b0;
		nx_off     = 1'b0;
		nx_clr     = 1'b0;
		case (kind_q)
			KIND_TICK: begin
				if (running_q) begin
					if (ramp_end) begin
						nx_running = 1'b0;
						nx_ratio   = RATIO_ONE;
						nx_step    = '0;
					end else begin
						nx_ratio = tick_sum[RATIO_W-1:0];
					end
				end
			end
			KIND_START: begin
				nx_running = glide_q;
				nx_ratio   = glide_q ? ratio_w_q : RATIO_ONE;
				nx_step    = glide_q ? step_w_q : '0;
				nx_on      = !note_trig_q;
				nx_trig    = 1'b1;
			end
			KIND_STOP: begin
				// held mono stop that allows tail-off is ignored; a stop never touches the glide
				if (!(mono_mode_q && key_q && tail_q)) begin
					nx_clr  = !tail_q;
					nx_off  = 1'b1;
					nx_trig = 1'b0;
				end
			end
			default: begin
			end
		endcase
		nx_shown = nx_running ? nx_ratio : RATIO_ONE;
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			glide_samples_q <= '0;
			mono_mode_q     <= 1'b0;
			note_trig_q     <= 1'b0;
			running_q       <= 1'b0;
			ratio_q         <= RATIO_ONE;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GLIDE_SAMPLES: glide_samples_q <= cfg_data;
					CFG_MONO_MODE:     mono_mode_q     <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.kind == KIND_START && glide_cond) begin
							state_q <= ratio_sat ? ST_MAG : ST_DIV1;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV1: begin
					if (!drsp.busy) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					state_q <= ST_DIV2;
				end
				ST_DIV2: begin
					if (!drsp.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						note_trig_q <= nx_trig;
						running_q   <= nx_running;
						ratio_q     <= nx_ratio;
						step_q      <= nx_step;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item latch, work values and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= req.kind;
			key_q     <= req.key_down;
			tail_q    <= req.allow_tail_off;
			glide_q   <= (req.kind == KIND_START) && glide_cond;
			ratio_w_q <= RATIO_MAX;
		end
		if (state_q == ST_DIV1 && !drsp.busy) begin
			ratio_w_q <= drsp.quotient;
		end
		if (state_q == ST_MAG) begin
			dir_q <= ratio_w_q > RATIO_ONE;
		end
		if (state_q == ST_DIV2 && !drsp.busy) begin
			step_w_q <= dir_q ? (~quo_x + 1'b1) : quo_x;
		end
		if (state_q == ST_FIN && slot_free) begin
			out_ratio_q  <= nx_shown[RATIO_W-1 -: SHOWN_W];
			out_active_q <= nx_running;
			out_on_q     <= nx_on;
			out_off_q    <= nx_off;
			out_clr_q    <= nx_clr;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.glide_ratio  = out_ratio_q;
	assign rsp.glide_active = out_active_q;
	assign rsp.gate_on      = out_on_q;
	assign rsp.gate_off     = out_off_q;
	assign rsp.clear_note   = out_clr_q;

`ifndef NO_ASSERTIONS
	// a result beat never both triggers and releases the envelopes
	a_on_off_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.gate_on && rsp.gate_off))
		else $error("gate_on and gate_off in one beat");

	// clearing the note always comes with a release
	a_clr_implies_off: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.clear_note |-> rsp.gate_off)
		else $error("clear_note without gate_off");

	// with no glide the shown ratio is exactly 1.0
	a_idle_ratio_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.glide_active |->
			rsp.glide_ratio == RATIO_ONE[RATIO_W-1 -: SHOWN_W])
		else $error("idle ratio is not 1.0");

	// the shared divider is idle whenever a new beat can be taken
	a_div_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !drsp.busy)
		else $error("divider busy while ready");

	// a running downward ramp has a ratio above 1.0
	a_ramp_side: assert property (@(posedge clk) disable iff (!arst_n)
		running_q && step_q[RATIO_W] |-> ratio_q > RATIO_ONE)
		else $error("downward ramp at or below 1.0");
`endif

endmodule
`default_nettype wire
